[hdl/esrc_pkg.sv]
// esrc_pkg: shared constants, beat types and verdict codes for the replay check
// no dependencies; imported by the top level and the checker

package esrc_pkg;

    // table size and derived address width
    localparam int NODE_COUNT = 16;
    localparam int ADDR_W     = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

    // field widths fixed by the packet header
    localparam int SLOT_W  = 4;
    localparam int EPOCH_W = 16;
    localparam int SEQ_W   = 16;
    localparam int ENTRY_W = EPOCH_W + SEQ_W;

    // verdict codes
    localparam logic [2:0] VERDICT_BASELINE  = 3'd0;
    localparam logic [2:0] VERDICT_FWD_SEQ   = 3'd1;
    localparam logic [2:0] VERDICT_NEW_EPOCH = 3'd2;
    localparam logic [2:0] VERDICT_STALE_SEQ = 3'd3;
    localparam logic [2:0] VERDICT_OLD_EPOCH = 3'd4;

    typedef struct packed {
        logic [SLOT_W-1:0]  node_slot;
        logic [EPOCH_W-1:0] packet_epoch;
        logic [SEQ_W-1:0]   packet_seq;
    } pkt_beat_t;

    typedef struct packed {
        logic       accepted;
        logic [2:0] verdict;
    } res_beat_t;

    // slot number to table address, zero-extended or truncated as the depth needs
    function automatic logic [ADDR_W-1:0] slot_to_addr(input logic [SLOT_W-1:0] slot);
        logic [ADDR_W+SLOT_W-1:0] ext;
        ext = {{ADDR_W{1'b0}}, slot};
        return ext[ADDR_W-1:0];
    endfunction

    // true when the slot names an entry of the table
    function automatic logic slot_in_range(input logic [SLOT_W-1:0] slot);
        logic [SLOT_W+9:0] ext;
        ext = {10'd0, slot};
        return ext < (SLOT_W + 10)'(NODE_COUNT);
    endfunction

    // strictly forward in the modular half-space: difference 1 to 32767
    function automatic logic ahead_half(input logic [15:0] now_val, input logic [15:0] ref_val);
        logic [15:0] diff;
        diff = now_val - ref_val;
        return (diff != 16'd0) && !diff[15];
    endfunction

endpackage

[hdl/esrc_ram.sv]
// esrc_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies; holds the per-node epoch and sequence table

module esrc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hdl/epoch_sequence_replay_check.sv]
// epoch_sequence_replay_check: per-node anti-replay filter on epoch and sequence
// depends on esrc_pkg and esrc_ram
//
//   channel  signals                     beat
//   pkt      pkt_valid / pkt_ready       node_slot, packet_epoch, packet_seq
//   res      res_valid / res_ready       accepted, verdict
//
// for each packet the accept edge issues the table read; ST_EVAL then evaluates the
// entry, writes it back and loads the result register once that register is free.
// reset clears the seen flags at once; the value table needs no clearing.
// a result waiting on res_ready holds the evaluation step, so pkt_ready stays low
// until the result register can take the next verdict.

module epoch_sequence_replay_check (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pkt_valid,
    output logic                 pkt_ready,
    input  esrc_pkg::pkt_beat_t  pkt,
    output logic                 res_valid,
    input  logic                 res_ready,
    output esrc_pkg::res_beat_t  res
);

    import esrc_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EVAL
    } state_t;

    state_t                  state_reg;
    logic [NODE_COUNT-1:0]   seen_reg;
    pkt_beat_t               pkt_reg;
    logic                    res_valid_reg;
    res_beat_t               res_reg;

    logic                    pkt_take;
    logic                    eval_go;
    logic [ADDR_W-1:0]       rd_addr;
    logic [ADDR_W-1:0]       cur_addr;
    logic [ENTRY_W-1:0]      entry;
    logic [EPOCH_W-1:0]      stored_epoch;
    logic [SEQ_W-1:0]        stored_seq;
    logic                    in_range;
    logic                    seen;
    res_beat_t               res_next;
    logic                    wr_en;

    // handshake
    assign pkt_ready = (state_reg == ST_IDLE);
    assign pkt_take  = pkt_valid && pkt_ready;
    assign eval_go   = (state_reg == ST_EVAL) && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // table addresses
    assign rd_addr  = slot_to_addr(pkt.node_slot);
    assign cur_addr = slot_to_addr(pkt_reg.node_slot);

    esrc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NODE_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (cur_addr),
        .wdata ({pkt_reg.packet_epoch, pkt_reg.packet_seq}),
        .re    (pkt_take),
        .raddr (rd_addr),
        .rdata (entry)
    );

    assign stored_epoch = entry[ENTRY_W-1:SEQ_W];
    assign stored_seq   = entry[SEQ_W-1:0];
    assign in_range     = slot_in_range(pkt_reg.node_slot);
    assign seen         = seen_reg[cur_addr];

    // verdict for the held packet
    always_comb
    begin
        res_next.accepted = 1'b0;
        res_next.verdict  = VERDICT_STALE_SEQ;
        priority if (!in_range)
        begin
            res_next.verdict = VERDICT_STALE_SEQ;
        end
        else if (!seen)
        begin
            res_next.accepted = 1'b1;
            res_next.verdict  = VERDICT_BASELINE;
        end
        else if (pkt_reg.packet_epoch == stored_epoch)
        begin
            if (ahead_half(pkt_reg.packet_seq, stored_seq))
            begin
                res_next.accepted = 1'b1;
                res_next.verdict  = VERDICT_FWD_SEQ;
            end
        end
        else if (ahead_half(pkt_reg.packet_epoch, stored_epoch))
        begin
            res_next.accepted = 1'b1;
            res_next.verdict  = VERDICT_NEW_EPOCH;
        end
        else
        begin
            res_next.verdict = VERDICT_OLD_EPOCH;
        end
    end

    // every accepted packet stores its own epoch and sequence
    assign wr_en = eval_go && res_next.accepted;

    // state, seen flags and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seen_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (res_valid_reg && res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (pkt_take)
                    begin
                        pkt_reg   <= pkt;
                        state_reg <= ST_EVAL;
                    end
                end
                ST_EVAL:
                begin
                    if (eval_go)
                    begin
                        res_reg       <= res_next;
                        res_valid_reg <= 1'b1;
                        if (wr_en)
                        begin
                            seen_reg[cur_addr] <= 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[hdl/esrc_checker.sv]
// esrc_checker: port-level assertions for the replay check, bound to the top level
// depends on esrc_pkg and epoch_sequence_replay_check

module esrc_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 pkt_valid,
    input logic                 pkt_ready,
    input esrc_pkg::pkt_beat_t  pkt,
    input logic                 res_valid,
    input logic                 res_ready,
    input esrc_pkg::res_beat_t  res
);

    import esrc_pkg::*;

    logic pkt_take;
    assign pkt_take = pkt_valid && pkt_ready;

    // an offered packet beat holds until taken
    a_pkt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_valid && !pkt_ready |=> pkt_valid && $stable(pkt))
        else $error("packet beat changed or dropped while waiting");

    // a pending result beat holds until taken
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result beat changed or dropped while stalled");

    // one packet in flight: no new packet beat right after one is taken
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_take |=> !pkt_ready)
        else $error("packet beat taken while another is being evaluated");

    // a fresh result beat must be preceded by a taken packet beat
    a_res_from_pkt: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(pkt_take, 2))
        else $error("result beat without a matching packet beat");

    // accepted flag agrees with the verdict code
    a_acc_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.accepted == ((res.verdict == VERDICT_BASELINE)
            || (res.verdict == VERDICT_FWD_SEQ) || (res.verdict == VERDICT_NEW_EPOCH))))
        else $error("accepted flag disagrees with verdict");

endmodule

bind epoch_sequence_replay_check esrc_checker u_esrc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pkt_valid (pkt_valid),
    .pkt_ready (pkt_ready),
    .pkt       (pkt),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
);
